### src/sgod_pkg.sv
package sgod_pkg;

  localparam int MaxPointsDefault = 1024;

  // Parse phase of the glyph record
  typedef enum logic [3:0] {
    PH_WAIT  = 4'd0,
    PH_HEAD  = 4'd1,
    PH_ENDS  = 4'd2,
    PH_ILEN  = 4'd3,
    PH_INST  = 4'd4,
    PH_FLAGS = 4'd5,
    PH_XS    = 4'd6,
    PH_YS    = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // Sequencer state of the engine
  typedef enum logic [2:0] {
    E_IDLE,
    E_FILL,
    E_SKRD,
    E_SKCK,
    E_XEX,
    E_YEX
  } eng_t;

  // Result kinds
  localparam logic [2:0] KIND_COUNT = 3'd0;
  localparam logic [2:0] KIND_BBOX  = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_INST  = 3'd3;
  localparam logic [2:0] KIND_POINT = 3'd4;
  localparam logic [2:0] KIND_ERROR = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_COMPOSITE = 2'd1;
  localparam logic [1:0] ERR_POINTS    = 2'd2;

  // Flag bit positions
  localparam int FB_XSHORT = 1;
  localparam int FB_YSHORT = 2;
  localparam int FB_REPEAT = 3;
  localparam int FB_XSAME  = 4;
  localparam int FB_YSAME  = 5;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        item_index;
    logic [15:0]        word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         point_flags;
    logic [1:0]         error_code;
    logic               last_of_glyph;
  } res_t;

endpackage

### src/sgod_if.sv
interface sgod_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       glyph_start;

  modport source (output valid, output data_byte, output glyph_start, input ready);
  modport sink (input valid, input data_byte, input glyph_start, output ready);
endinterface

interface sgod_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [15:0]        item_index;
  logic [15:0]        word_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [7:0]         point_flags;
  logic [1:0]         error_code;
  logic               last_of_glyph;

  modport source (output valid, output kind, output item_index, output word_value,
                  output point_x, output point_y, output point_flags,
                  output error_code, output last_of_glyph, input ready);
  modport sink (input valid, input kind, input item_index, input word_value,
                input point_x, input point_y, input point_flags,
                input error_code, input last_of_glyph, output ready);
endinterface

### src/sgod_ram.sv
module sgod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sgod_core.sv
module sgod_core #(
  parameter int MAX_POINTS = sgod_pkg::MaxPointsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_start,
  input  logic                          out_free,
  output logic                          res_load,
  output sgod_pkg::res_t                res,
  output logic                          fl_we,
  output logic [$clog2(MAX_POINTS)-1:0] fl_waddr,
  output logic [7:0]                    fl_wdata,
  input  logic [7:0]                    fl_rdata,
  output logic                          x_we,
  output logic [$clog2(MAX_POINTS)-1:0] x_waddr,
  output logic [31:0]                   x_wdata,
  input  logic [31:0]                   x_rdata,
  output logic [$clog2(MAX_POINTS)-1:0] raddr
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int FCW  = (CW > 16) ? CW : 16;

  sgod_pkg::phase_t phase, phase_next;
  sgod_pkg::eng_t   eng, eng_next;
  logic [7:0]       hi, hi_next;
  logic             half, half_next;
  logic [FCW-1:0]   fc, fc_next;
  logic [15:0]      ct, ct_next;
  logic [15:0]      pt, pt_next;
  logic [15:0]      rem, rem_next;
  logic             rep, rep_next;
  logic [31:0]      rx, rx_next;
  logic [31:0]      ry, ry_next;
  logic [7:0]       lastf, lastf_next;
  logic [7:0]       blat, blat_next;
  logic [FCW-1:0]   fill_cnt, fill_cnt_next;

  // Effective view of the record state, with a glyph start folded in
  logic             acc, gs;
  sgod_pkg::phase_t ph_e;
  logic             half_e;
  logic [FCW-1:0]   fc_e;
  logic [15:0]      ct_e;
  logic [7:0]       b_cur;
  logic [15:0]      word;
  logic [FCW-1:0]   n_pts;
  logic [FCW-1:0]   room, run;
  logic             end_last, too_many, fc_done, fc_last;
  logic             xneed, yneed;
  logic [31:0]      bext, dx, dy, rx_sum, ry_sum;

  assign acc    = in_valid && in_ready;
  assign gs     = acc && in_start;
  assign ph_e   = gs ? sgod_pkg::PH_HEAD : phase;
  assign half_e = gs ? 1'b0 : half;
  assign fc_e   = gs ? '0 : fc;
  assign ct_e   = gs ? 16'd0 : ct;
  assign b_cur  = (eng == sgod_pkg::E_IDLE) ? in_byte : blat;
  assign word   = {hi, b_cur};
  assign n_pts  = FCW'(pt) + FCW'(1);
  assign room   = n_pts - fc;
  assign run    = (FCW'(in_byte) < room) ? FCW'(in_byte) : room;
  assign end_last = ({1'b0, fc} + (FCW+1)'(1)) >= (FCW+1)'(ct);
  assign too_many = 32'(word) >= 32'(MAX_POINTS);
  assign fc_done  = fc >= n_pts;
  assign fc_last  = ({1'b0, fc} + (FCW+1)'(1)) >= {1'b0, n_pts};

  // Delta decode from the flag read out of the store
  assign xneed  = !fl_rdata[sgod_pkg::FB_XSHORT];
  assign yneed  = !fl_rdata[sgod_pkg::FB_YSHORT] && !fl_rdata[sgod_pkg::FB_YSAME];
  assign bext   = {24'd0, blat};
  assign dx     = !xneed ? (fl_rdata[sgod_pkg::FB_XSAME] ? bext : (32'd0 - bext))
                         : {{16{word[15]}}, word};
  assign dy     = fl_rdata[sgod_pkg::FB_YSHORT]
                  ? (fl_rdata[sgod_pkg::FB_YSAME] ? bext : (32'd0 - bext))
                  : (fl_rdata[sgod_pkg::FB_YSAME] ? 32'd0 : {{16{word[15]}}, word});
  assign rx_sum = rx + dx;
  assign ry_sum = ry + dy;

  // Next state
  always_comb begin
    phase_next    = phase;
    eng_next      = eng;
    hi_next       = hi;
    half_next     = half;
    fc_next       = fc;
    ct_next       = ct;
    pt_next       = pt;
    rem_next      = rem;
    rep_next      = rep;
    rx_next       = rx;
    ry_next       = ry;
    lastf_next    = lastf;
    blat_next     = blat;
    fill_cnt_next = fill_cnt;
    unique case (eng)
      sgod_pkg::E_IDLE: begin
        if (acc) begin
          blat_next = in_byte;
          if (gs) begin
            phase_next = sgod_pkg::PH_HEAD;
            hi_next    = 8'd0;
            half_next  = 1'b0;
            fc_next    = '0;
            ct_next    = 16'd0;
            pt_next    = 16'd0;
            rem_next   = 16'd0;
            rep_next   = 1'b0;
            rx_next    = 32'd0;
            ry_next    = 32'd0;
          end
          case (ph_e)
            sgod_pkg::PH_HEAD: begin
              if (!half_e) begin
                hi_next   = in_byte;
                half_next = 1'b1;
              end else begin
                half_next = 1'b0;
                if (fc_e == '0) begin
                  if (word[15]) begin
                    phase_next = sgod_pkg::PH_DONE;
                  end else begin
                    ct_next = word;
                    fc_next = FCW'(1);
                  end
                end else if (fc_e >= FCW'(4)) begin
                  phase_next = (ct_e == 16'd0) ? sgod_pkg::PH_DONE : sgod_pkg::PH_ENDS;
                  fc_next    = '0;
                end else begin
                  fc_next = fc_e + FCW'(1);
                end
              end
            end
            sgod_pkg::PH_ENDS: begin
              if (!half) begin
                hi_next   = in_byte;
                half_next = 1'b1;
              end else begin
                half_next = 1'b0;
                if (end_last) begin
                  if (too_many) begin
                    phase_next = sgod_pkg::PH_DONE;
                  end else begin
                    pt_next    = word;
                    phase_next = sgod_pkg::PH_ILEN;
                    fc_next    = '0;
                  end
                end else begin
                  fc_next = fc + FCW'(1);
                end
              end
            end
            sgod_pkg::PH_ILEN: begin
              if (!half) begin
                hi_next   = in_byte;
                half_next = 1'b1;
              end else begin
                half_next  = 1'b0;
                rem_next   = word;
                fc_next    = '0;
                phase_next = (word != 16'd0) ? sgod_pkg::PH_INST : sgod_pkg::PH_FLAGS;
              end
            end
            sgod_pkg::PH_INST: begin
              fc_next  = fc + FCW'(1);
              rem_next = rem - 16'd1;
              if (rem == 16'd1) begin
                phase_next = sgod_pkg::PH_FLAGS;
                fc_next    = '0;
              end
            end
            sgod_pkg::PH_FLAGS: begin
              if (rep) begin
                rep_next = 1'b0;
                if (run != '0) begin
                  fill_cnt_next = run;
                  eng_next      = sgod_pkg::E_FILL;
                end else if (fc_done) begin
                  phase_next = sgod_pkg::PH_XS;
                  fc_next    = '0;
                  eng_next   = sgod_pkg::E_SKRD;
                end
              end else begin
                fc_next    = fc + FCW'(1);
                lastf_next = in_byte;
                if (in_byte[sgod_pkg::FB_REPEAT]) begin
                  rep_next = 1'b1;
                end else if (fc_last) begin
                  phase_next = sgod_pkg::PH_XS;
                  fc_next    = '0;
                  eng_next   = sgod_pkg::E_SKRD;
                end
              end
            end
            sgod_pkg::PH_XS: eng_next = sgod_pkg::E_XEX;
            sgod_pkg::PH_YS: eng_next = sgod_pkg::E_YEX;
            default: ;
          endcase
        end
      end
      sgod_pkg::E_FILL: begin
        fc_next       = fc + FCW'(1);
        fill_cnt_next = fill_cnt - FCW'(1);
        if (fill_cnt == FCW'(1)) begin
          if (fc_last) begin
            phase_next = sgod_pkg::PH_XS;
            fc_next    = '0;
            eng_next   = sgod_pkg::E_SKRD;
          end else begin
            eng_next = sgod_pkg::E_IDLE;
          end
        end
      end
      sgod_pkg::E_SKRD: begin
        if (fc_done) begin
          phase_next = sgod_pkg::PH_YS;
          fc_next    = '0;
          eng_next   = sgod_pkg::E_IDLE;
        end else begin
          eng_next = sgod_pkg::E_SKCK;
        end
      end
      sgod_pkg::E_SKCK: begin
        if (fl_rdata[sgod_pkg::FB_XSHORT] || !fl_rdata[sgod_pkg::FB_XSAME]) begin
          eng_next = sgod_pkg::E_IDLE;
        end else begin
          fc_next  = fc + FCW'(1);
          eng_next = sgod_pkg::E_SKRD;
        end
      end
      sgod_pkg::E_XEX: begin
        if (xneed && !half) begin
          hi_next   = blat;
          half_next = 1'b1;
          eng_next  = sgod_pkg::E_IDLE;
        end else begin
          half_next = 1'b0;
          rx_next   = rx_sum;
          fc_next   = fc + FCW'(1);
          eng_next  = sgod_pkg::E_SKRD;
        end
      end
      sgod_pkg::E_YEX: begin
        if (yneed && !half) begin
          hi_next   = blat;
          half_next = 1'b1;
          eng_next  = sgod_pkg::E_IDLE;
        end else if (out_free) begin
          half_next = 1'b0;
          ry_next   = ry_sum;
          fc_next   = fc + FCW'(1);
          eng_next  = sgod_pkg::E_IDLE;
          if (fc_last) begin
            phase_next = sgod_pkg::PH_DONE;
          end
        end
      end
      default: eng_next = sgod_pkg::E_IDLE;
    endcase
  end

  // Outputs: handshake, store ports and result
  always_comb begin
    in_ready = (eng == sgod_pkg::E_IDLE) && out_free;
    raddr    = fc[AW-1:0];
    fl_waddr = fc[AW-1:0];
    x_waddr  = fc[AW-1:0];
    fl_we    = (eng == sgod_pkg::E_FILL) ||
               (acc && ph_e == sgod_pkg::PH_FLAGS && !rep);
    fl_wdata = (eng == sgod_pkg::E_FILL) ? lastf : in_byte;
    x_we     = 1'b0;
    x_wdata  = rx;
    if (eng == sgod_pkg::E_SKCK) begin
      x_we = !(fl_rdata[sgod_pkg::FB_XSHORT] || !fl_rdata[sgod_pkg::FB_XSAME]);
    end else if (eng == sgod_pkg::E_XEX) begin
      x_we    = !xneed || half;
      x_wdata = rx_sum;
    end
    res_load = 1'b0;
    res      = '0;
    if (acc && half_e && ph_e == sgod_pkg::PH_HEAD) begin
      res_load        = 1'b1;
      res.word_value  = word;
      if (fc_e == '0) begin
        if (word[15]) begin
          res.kind          = sgod_pkg::KIND_ERROR;
          res.error_code    = sgod_pkg::ERR_COMPOSITE;
          res.last_of_glyph = 1'b1;
        end else begin
          res.kind = sgod_pkg::KIND_COUNT;
        end
      end else begin
        res.kind          = sgod_pkg::KIND_BBOX;
        res.item_index    = fc_e[15:0] - 16'd1;
        res.last_of_glyph = (fc_e == FCW'(4)) && (ct_e == 16'd0);
      end
    end else if (acc && half_e && ph_e == sgod_pkg::PH_ENDS) begin
      res_load       = 1'b1;
      res.word_value = word;
      if (end_last && too_many) begin
        res.kind          = sgod_pkg::KIND_ERROR;
        res.error_code    = sgod_pkg::ERR_POINTS;
        res.last_of_glyph = 1'b1;
      end else begin
        res.kind       = sgod_pkg::KIND_END;
        res.item_index = fc[15:0];
      end
    end else if (acc && ph_e == sgod_pkg::PH_INST) begin
      res_load       = 1'b1;
      res.kind       = sgod_pkg::KIND_INST;
      res.item_index = fc[15:0];
      res.word_value = {8'd0, in_byte};
    end else if (eng == sgod_pkg::E_YEX && (!yneed || half) && out_free) begin
      res_load          = 1'b1;
      res.kind          = sgod_pkg::KIND_POINT;
      res.item_index    = fc[15:0];
      res.point_x       = x_rdata;
      res.point_y       = ry_sum;
      res.point_flags   = fl_rdata;
      res.last_of_glyph = fc_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= sgod_pkg::PH_WAIT;
      eng      <= sgod_pkg::E_IDLE;
      hi       <= 8'd0;
      half     <= 1'b0;
      fc       <= '0;
      ct       <= 16'd0;
      pt       <= 16'd0;
      rem      <= 16'd0;
      rep      <= 1'b0;
      rx       <= 32'd0;
      ry       <= 32'd0;
      fill_cnt <= '0;
    end else begin
      phase    <= phase_next;
      eng      <= eng_next;
      hi       <= hi_next;
      half     <= half_next;
      fc       <= fc_next;
      ct       <= ct_next;
      pt       <= pt_next;
      rem      <= rem_next;
      rep      <= rep_next;
      rx       <= rx_next;
      ry       <= ry_next;
      fill_cnt <= fill_cnt_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lastf <= lastf_next;
    blat  <= blat_next;
  end

`ifndef SYNTHESIS
  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == sgod_pkg::PH_FLAGS || phase == sgod_pkg::PH_YS) |-> (fc <= n_pts))
    else $error("point counter past point count");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    (eng == sgod_pkg::E_FILL) |-> (fill_cnt != '0) && (fc < n_pts))
    else $error("repeat fill out of range");
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded into a full output register");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(fl_we && x_we))
    else $error("flag and x stores written together");
  a_fill_from_flags: assert property (@(posedge clk) disable iff (rst)
    (eng == sgod_pkg::E_FILL) |-> $past(eng) == sgod_pkg::E_FILL ||
      $past(phase) == sgod_pkg::PH_FLAGS)
    else $error("repeat fill outside flag phase");
`endif

endmodule

### src/simple_glyph_outline_decoder_top.sv
// Channel  | Dir | Fields
// in_ch    | in  | data_byte[7:0], glyph_start
// out_ch   | out | kind, item_index, word_value, point_x, point_y, point_flags,
//          |     | error_code, last_of_glyph
//
// Header, contour end, length and instruction bytes are taken directly; a flag byte is
// stored as it is taken, and a repeat count copies the flag into each point of its run.
// After the last flag byte the sequencer reads the next flag, checks whether it needs an
// x byte, and writes the running x for each leading point with no x byte. A y byte and
// the high byte of a word x delta wait on the store read of the flag; an x byte that ends
// a delta writes x, then reads and checks the next flag in the same way.
// One item at a time; a byte is taken only when the sequencer is idle and the output
// register is empty or being drained, so a stalled sink holds the input back; a point
// waits in the sequencer until the output register is free.
// Reset is synchronous; the flag and x stores are not cleared, each entry is written
// for a glyph before it is read.
module simple_glyph_outline_decoder_top #(
  parameter int MAX_POINTS = sgod_pkg::MaxPointsDefault
) (
  input logic       clk,
  input logic       rst,
  sgod_in_if.sink   in_ch,
  sgod_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_POINTS);

  logic           out_free, res_load;
  sgod_pkg::res_t res, oreg;
  logic           ovalid;
  logic           fl_we, x_we;
  logic [AW-1:0]  fl_waddr, x_waddr, raddr;
  logic [7:0]     fl_wdata, fl_rdata;
  logic [31:0]    x_wdata, x_rdata;

  assign out_free = !ovalid || out_ch.ready;

  sgod_core #(.MAX_POINTS(MAX_POINTS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .in_start (in_ch.glyph_start),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .fl_we    (fl_we),
    .fl_waddr (fl_waddr),
    .fl_wdata (fl_wdata),
    .fl_rdata (fl_rdata),
    .x_we     (x_we),
    .x_waddr  (x_waddr),
    .x_wdata  (x_wdata),
    .x_rdata  (x_rdata),
    .raddr    (raddr)
  );

  sgod_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_flag_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (raddr),
    .rdata (fl_rdata)
  );

  sgod_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (raddr),
    .rdata (x_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      oreg <= res;
    end
  end

  assign out_ch.valid         = ovalid;
  assign out_ch.kind          = oreg.kind;
  assign out_ch.item_index    = oreg.item_index;
  assign out_ch.word_value    = oreg.word_value;
  assign out_ch.point_x       = oreg.point_x;
  assign out_ch.point_y       = oreg.point_y;
  assign out_ch.point_flags   = oreg.point_flags;
  assign out_ch.error_code    = oreg.error_code;
  assign out_ch.last_of_glyph = oreg.last_of_glyph;

endmodule

### verif/simple_glyph_outline_decoder_top_tb.sv
`timescale 1ns / 1ps

module simple_glyph_outline_decoder_top_tb;

  localparam int MAXP = sgod_pkg::MaxPointsDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgod_in_if  in_ch ();
  sgod_out_if out_ch ();

  simple_glyph_outline_decoder_top #(.MAX_POINTS(MAXP)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [7:0] b;
    logic       gs;
  } byte_xfer_t;

  byte_xfer_t     stim_q[$];
  sgod_pkg::res_t outline_q[$];
  int             fail_cnt = 0;
  bit             src_idle_en = 1'b1;
  bit             snk_idle_en = 1'b1;
  int             stall_left = 0;

  // Decoder state mirror
  sgod_pkg::phase_t phase = sgod_pkg::PH_WAIT;
  logic [7:0]  hold;
  logic [31:0] fcnt, ncont, last_pt, inst_left, sum_x, sum_y;
  bit          rep_pend, half;
  logic [7:0]  flag_mem [MAXP];
  logic [31:0] xpos_mem [MAXP];

  function automatic void restart_glyph();
    phase = sgod_pkg::PH_HEAD;
    hold = '0;
    fcnt = 0;
    ncont = 0;
    last_pt = 0;
    inst_left = 0;
    rep_pend = 1'b0;
    sum_x = 0;
    sum_y = 0;
    half = 1'b0;
  endfunction

  // Big-endian word assembly; returns 1 when the low byte completes the word
  function automatic bit grab_word(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    if (!half) begin
      hold = b;
      half = 1'b1;
      return 1'b0;
    end
    half = 1'b0;
    w = {hold, b};
    return 1'b1;
  endfunction

  // Points whose x delta takes no byte just copy the running x
  function automatic void advance_same_x();
    logic [7:0] f;
    while (fcnt < last_pt + 1 && fcnt < MAXP) begin
      f = flag_mem[fcnt];
      if (f[sgod_pkg::FB_XSHORT] || !f[sgod_pkg::FB_XSAME]) break;
      xpos_mem[fcnt] = sum_x;
      fcnt++;
    end
    if (fcnt >= last_pt + 1 || fcnt >= MAXP) begin
      phase = sgod_pkg::PH_YS;
      fcnt = 0;
    end
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic gs,
                                     output sgod_pkg::res_t r);
    logic [15:0] w;
    logic [7:0]  f, prev;
    logic [31:0] d, n, room, run;
    bit          lst;
    r = '0;
    if (gs) restart_glyph();
    n = last_pt + 1;
    case (phase)
      sgod_pkg::PH_HEAD: begin
        if (!grab_word(b, w)) return 1'b0;
        if (fcnt == 0) begin
          r.word_value = w;
          if (w[15]) begin
            r.kind = sgod_pkg::KIND_ERROR;
            r.error_code = sgod_pkg::ERR_COMPOSITE;
            r.last_of_glyph = 1'b1;
            phase = sgod_pkg::PH_DONE;
            return 1'b1;
          end
          ncont = 32'(w);
          r.kind = sgod_pkg::KIND_COUNT;
          fcnt = 1;
          return 1'b1;
        end
        r.kind = sgod_pkg::KIND_BBOX;
        r.item_index = 16'(fcnt - 1);
        r.word_value = w;
        r.last_of_glyph = (fcnt == 4 && ncont == 0);
        if (fcnt >= 4) begin
          phase = (ncont == 0) ? sgod_pkg::PH_DONE : sgod_pkg::PH_ENDS;
          fcnt = 0;
        end else begin
          fcnt++;
        end
        return 1'b1;
      end
      sgod_pkg::PH_ENDS: begin
        if (!grab_word(b, w)) return 1'b0;
        r.word_value = w;
        if (fcnt + 1 >= ncont) begin
          if (32'(w) + 1 > MAXP) begin
            r.kind = sgod_pkg::KIND_ERROR;
            r.error_code = sgod_pkg::ERR_POINTS;
            r.last_of_glyph = 1'b1;
            phase = sgod_pkg::PH_DONE;
            return 1'b1;
          end
          last_pt = 32'(w);
          r.kind = sgod_pkg::KIND_END;
          r.item_index = 16'(fcnt);
          phase = sgod_pkg::PH_ILEN;
          fcnt = 0;
          return 1'b1;
        end
        r.kind = sgod_pkg::KIND_END;
        r.item_index = 16'(fcnt);
        fcnt++;
        return 1'b1;
      end
      sgod_pkg::PH_ILEN: begin
        if (!grab_word(b, w)) return 1'b0;
        inst_left = 32'(w);
        fcnt = 0;
        phase = (w != 0) ? sgod_pkg::PH_INST : sgod_pkg::PH_FLAGS;
        return 1'b0;
      end
      sgod_pkg::PH_INST: begin
        r.kind = sgod_pkg::KIND_INST;
        r.item_index = 16'(fcnt);
        r.word_value = {8'h00, b};
        fcnt++;
        inst_left = (inst_left - 1) & 32'hFFFF;
        if (inst_left == 0) begin
          phase = sgod_pkg::PH_FLAGS;
          fcnt = 0;
        end
        return 1'b1;
      end
      sgod_pkg::PH_FLAGS: begin
        if (rep_pend) begin
          room = (n > fcnt) ? n - fcnt : 0;
          run = (32'(b) < room) ? 32'(b) : room;
          prev = (fcnt >= 1 && fcnt - 1 < MAXP) ? flag_mem[fcnt - 1] : 8'h00;
          for (int k = 0; k < run && fcnt < MAXP; k++) begin
            flag_mem[fcnt] = prev;
            fcnt++;
          end
          rep_pend = 1'b0;
        end else if (fcnt < MAXP) begin
          flag_mem[fcnt] = b;
          fcnt++;
          if (b[sgod_pkg::FB_REPEAT]) rep_pend = 1'b1;
        end
        if (!rep_pend && (fcnt >= n || fcnt >= MAXP)) begin
          fcnt = 0;
          phase = sgod_pkg::PH_XS;
          advance_same_x();
        end
        return 1'b0;
      end
      sgod_pkg::PH_XS: begin
        if (fcnt >= MAXP) begin
          phase = sgod_pkg::PH_DONE;
          return 1'b0;
        end
        f = flag_mem[fcnt];
        if (f[sgod_pkg::FB_XSHORT]) begin
          d = f[sgod_pkg::FB_XSAME] ? 32'(b) : 32'(0) - 32'(b);
        end else begin
          if (!grab_word(b, w)) return 1'b0;
          d = {{16{w[15]}}, w};
        end
        sum_x += d;
        xpos_mem[fcnt] = sum_x;
        fcnt++;
        advance_same_x();
        return 1'b0;
      end
      sgod_pkg::PH_YS: begin
        if (fcnt >= MAXP) begin
          phase = sgod_pkg::PH_DONE;
          return 1'b0;
        end
        f = flag_mem[fcnt];
        if (f[sgod_pkg::FB_YSHORT]) begin
          d = f[sgod_pkg::FB_YSAME] ? 32'(b) : 32'(0) - 32'(b);
        end else if (f[sgod_pkg::FB_YSAME]) begin
          d = 0;
        end else begin
          if (!grab_word(b, w)) return 1'b0;
          d = {{16{w[15]}}, w};
        end
        sum_y += d;
        lst = (fcnt + 1 >= n);
        r.kind = sgod_pkg::KIND_POINT;
        r.item_index = 16'(fcnt);
        r.point_x = xpos_mem[fcnt];
        r.point_y = sum_y;
        r.point_flags = f;
        r.last_of_glyph = lst;
        fcnt++;
        if (lst) phase = sgod_pkg::PH_DONE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Gap length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stimulus construction
  function automatic void push_byte(input logic [7:0] b, input logic gs);
    byte_xfer_t x;
    x.b = b;
    x.gs = gs;
    stim_q.push_back(x);
  endfunction

  function automatic void push_word(input logic [15:0] w, input logic gs);
    push_byte(w[15:8], gs);
    push_byte(w[7:0], 1'b0);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Well-formed simple glyph; last_end is the final contour end point
  function automatic void build_glyph(input int nc, input int last_end, input int ilen,
                                      input int rep_pct);
    logic [7:0] ex[$];
    int         held[$];
    logic [7:0] f;
    int         npts, remain, cnt, run;
    push_word(16'(nc), 1'b1);
    for (int i = 0; i < 4; i++) push_word(rand_word(), 1'b0);
    if (nc == 0) return;
    for (int i = 0; i < nc; i++)
      push_word((i == nc - 1) ? 16'(last_end) : 16'($urandom), 1'b0);
    if (last_end + 1 > MAXP) return;
    npts = last_end + 1;
    push_word(16'(ilen), 1'b0);
    for (int i = 0; i < ilen; i++) push_byte(8'($urandom), 1'b0);
    // flags, with repeat runs that sometimes overrun the point count
    while (ex.size() < npts) begin
      f = 8'($urandom);
      if ($urandom_range(0, 99) >= rep_pct) f[sgod_pkg::FB_REPEAT] = 1'b0;
      push_byte(f, 1'b0);
      ex.push_back(f);
      if (f[sgod_pkg::FB_REPEAT]) begin
        remain = npts - ex.size();
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, (remain > 255) ? 255 : remain);
        push_byte(8'(cnt), 1'b0);
        run = (cnt < remain) ? cnt : remain;
        for (int k = 0; k < run; k++) ex.push_back(f);
      end
    end
    // x deltas
    foreach (ex[i]) begin
      if (ex[i][sgod_pkg::FB_XSHORT]) push_byte(8'($urandom), 1'b0);
      else if (!ex[i][sgod_pkg::FB_XSAME]) push_word(rand_word(), 1'b0);
    end
    // y deltas; a same-y point takes a slot that repeats the next byte
    foreach (ex[i]) begin
      if (ex[i][sgod_pkg::FB_YSHORT]) begin
        push_byte(8'($urandom), 1'b0);
      end else if (ex[i][sgod_pkg::FB_YSAME]) begin
        held.push_back(stim_q.size());
        push_byte(8'h00, 1'b0);
      end else begin
        push_word(rand_word(), 1'b0);
      end
    end
    foreach (held[i])
      if (held[i] + 1 < stim_q.size()) stim_q[held[i]].b = stim_q[held[i] + 1].b;
  endfunction

  function automatic void push_noise(input int cnt);
    for (int i = 0; i < cnt; i++) push_byte(8'($urandom), 1'b0);
  endfunction

  // One input transfer, predicted on acceptance
  task automatic send_byte(input logic [7:0] b, input logic gs);
    int             gap;
    sgod_pkg::res_t r;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.glyph_start <= gs;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_byte(b, gs, r)) outline_q.push_back(r);
  endtask

  task automatic flush_stim();
    foreach (stim_q[i]) send_byte(stim_q[i].b, stim_q[i].gs);
    stim_q.delete();
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (outline_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (1100) @(posedge clk);
  endtask

  // Result checking and sink-side stalls
  always @(posedge clk) begin
    sgod_pkg::res_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 99) < 4) begin
        stall_left <= $urandom_range(10, 40);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !snk_idle_en || ($urandom_range(0, 99) < 70);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.item_index = out_ch.item_index;
        got.word_value = out_ch.word_value;
        got.point_x = out_ch.point_x;
        got.point_y = out_ch.point_y;
        got.point_flags = out_ch.point_flags;
        got.error_code = out_ch.error_code;
        got.last_of_glyph = out_ch.last_of_glyph;
        if (outline_q.size() == 0) begin
          $error("unexpected result transfer, kind %0d", got.kind);
          fail_cnt++;
        end else begin
          want = outline_q.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: exp %0d got %0d", want.kind, got.kind);
            fail_cnt++;
          end
          if (got.item_index !== want.item_index) begin
            $error("item_index: exp %0d got %0d", want.item_index, got.item_index);
            fail_cnt++;
          end
          if (got.word_value !== want.word_value) begin
            $error("word_value: exp %h got %h", want.word_value, got.word_value);
            fail_cnt++;
          end
          if (got.point_x !== want.point_x) begin
            $error("point_x: exp %0d got %0d", want.point_x, got.point_x);
            fail_cnt++;
          end
          if (got.point_y !== want.point_y) begin
            $error("point_y: exp %0d got %0d", want.point_y, got.point_y);
            fail_cnt++;
          end
          if (got.point_flags !== want.point_flags) begin
            $error("point_flags: exp %h got %h", want.point_flags, got.point_flags);
            fail_cnt++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code: exp %0d got %0d", want.error_code, got.error_code);
            fail_cnt++;
          end
          if (got.last_of_glyph !== want.last_of_glyph) begin
            $error("last_of_glyph: exp %0d got %0d", want.last_of_glyph, got.last_of_glyph);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Header corner cases: bytes before any record, empty, composite, point overflow
  task automatic test_header_cases();
    push_noise(3);
    build_glyph(0, 0, 0, 0);
    push_noise(2);
    push_word(16'h8000, 1'b1);
    push_word(16'hFFFF, 1'b1);
    build_glyph(1, MAXP, 0, 0);
    build_glyph(2, 16'hFFFF, 0, 0);
    flush_stim();
  endtask

  // Small glyphs: single point, instructions, repeat on last flag, abandoned record
  task automatic test_small_outlines();
    build_glyph(1, 0, 3, 0);
    build_glyph(2, 5, 0, 100);
    build_glyph(3, 3, 1, 50);
    repeat (6) void'(stim_q.pop_back());
    build_glyph(1, 2, 0, 30);
    push_noise(4);
    flush_stim();
  endtask

  // Full point capacity, sender held until everything has drained
  task automatic test_capacity();
    wait_drain();
    build_glyph(1, MAXP - 1, 2, 20);
    flush_stim();
    wait_drain();
  endtask

  // Random mix, mostly well-formed glyphs
  task automatic test_random_glyphs();
    int sent, sel, sz;
    sent = 0;
    while (sent < 800) begin
      src_idle_en = ($urandom_range(0, 4) != 0);
      snk_idle_en = ($urandom_range(0, 4) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 75) build_glyph($urandom_range(1, 3), $urandom_range(0, 11),
                                $urandom_range(0, 4), 25);
      else if (sel < 83) build_glyph(0, 0, 0, 0);
      else if (sel < 88) push_word(16'h8000 | 16'($urandom), 1'b1);
      else if (sel < 92) build_glyph($urandom_range(1, 2), $urandom_range(MAXP, 65535), 0, 0);
      else begin
        build_glyph($urandom_range(1, 3), $urandom_range(0, 11), $urandom_range(0, 4), 25);
        sz = stim_q.size();
        repeat ($urandom_range(1, sz - 1)) void'(stim_q.pop_back());
        if ($urandom_range(0, 1) == 0) push_noise($urandom_range(1, 5));
      end
      if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 4));
      sent += stim_q.size();
      flush_stim();
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.glyph_start = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_cases();
    test_small_outlines();
    test_capacity();
    test_random_glyphs();
    wait_drain();
    if (outline_q.size() != 0) begin
      $error("%0d expected results never arrived", outline_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/sgod_pkg.sv
src/sgod_if.sv
src/sgod_ram.sv
src/sgod_core.sv
src/simple_glyph_outline_decoder_top.sv
verif/simple_glyph_outline_decoder_top_tb.sv
